// ===== hw/rtl/ign_pkg.sv =====
// Shared constants, types and arithmetic helpers for the gradient noise block.
`timescale 1ns / 1ps
package ign_pkg;
    localparam int FRAC_BITS  = 16;
    localparam int TABLE_SIZE = 256;
    localparam int TBL_AW     = $clog2(TABLE_SIZE);
    localparam int VW         = FRAC_BITS + 4;
    localparam int FW         = FRAC_BITS + 1;
    localparam int PW         = FW + 1 + VW;
    localparam int OUT_W      = 19;

    localparam logic [VW-1:0] ONE_V = {3'b000, 1'b1, {FRAC_BITS{1'b0}}};

    typedef enum logic [1:0] {
        OP_NOISE3 = 2'd0,
        OP_NOISE2 = 2'd1,
        OP_WRITE  = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef logic [TBL_AW-1:0]    t_tidx;
    typedef logic signed [VW-1:0] t_val;
    typedef logic [FRAC_BITS-1:0] t_frac;
    typedef logic [FW-1:0]        t_fade;
    typedef logic signed [PW-1:0] t_prod;

    localparam logic [7:0] STD_PERM [256] = '{
        8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,
        8'd201,8'd95,8'd96,8'd53,8'd194,8'd233,8'd7,8'd225,
        8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
        8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,
        8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,
        8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
        8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,
        8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
        8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
        8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,
        8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
        8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
        8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,
        8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,
        8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
        8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,
        8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,
        8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
        8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,
        8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,
        8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
        8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
        8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,
        8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
        8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
        8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,
        8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
        8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
        8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,
        8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
        8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
        8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
    };

    function automatic t_tidx byte_idx(input logic [7:0] b);
        logic [TBL_AW+7:0] tmp;
        tmp = {{TBL_AW{1'b0}}, b};
        return tmp[TBL_AW-1:0];
    endfunction

    function automatic logic [7:0] low_byte(input t_tidx i);
        logic [TBL_AW+7:0] tmp;
        tmp = {8'b0, i};
        return tmp[7:0];
    endfunction

    function automatic t_prod fx_mul(input t_fade t, input t_val d);
        return $signed({1'b0, t}) * d;
    endfunction

    function automatic t_val fx_shr(input t_prod p);
        t_prod s;
        s = p >>> FRAC_BITS;
        return s[VW-1:0];
    endfunction

    function automatic t_val grad3(input logic [3:0] h, input t_val x, input t_val y,
                                   input t_val z);
        t_val u;
        t_val v;
        u = (h < 4'd8) ? x : y;
        v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
        if (h[0]) u = -u;
        if (h[1]) v = -v;
        return u + v;
    endfunction

    function automatic t_val grad2(input logic [1:0] h, input t_val x, input t_val y);
        t_val r;
        unique case (h)
            2'd0:    r = x + y;
            2'd1:    r = y - x;
            2'd2:    r = x - y;
            default: r = -x - y;
        endcase
        return r;
    endfunction
endpackage

// ===== hw/rtl/ign_if.sv =====
// Valid/ready channel interfaces for noise requests and results.
`timescale 1ns / 1ps
interface ign_in_if import ign_pkg::*;;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [7:0]         entry_index;
    logic [7:0]         entry_value;
    modport source(output valid, opcode, coord_x, coord_y, coord_z, entry_index,
                   entry_value, input ready);
    modport sink(input valid, opcode, coord_x, coord_y, coord_z, entry_index,
                 entry_value, output ready);
endinterface

interface ign_out_if import ign_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] noise_value;
    modport source(output valid, noise_value, input ready);
    modport sink(input valid, noise_value, output ready);
endinterface

// ===== hw/rtl/improved_gradient_noise.sv =====
// Top level: improved gradient noise, 3D/2D evaluation and table writes.
//
//  port    dir  beat contents
//  i_in    in   opcode, coord_x/y/z (Q16.16), entry_index, entry_value
//  o_out   out  noise_value (Q2.16), one beat per noise request
//
// One request per cycle unless the pipeline holds, the table is loading or a table write waits.
// Table lookups take three chained registered reads from seven table copies.
// After reset the table is loaded with the standard permutation, one entry a
// cycle until all TABLE_SIZE entries are written, with i_in.ready low.
// A table write waits until no noise beat sits in the second or third lookup read.
// The whole pipeline holds when the output register is full and not taken.
`timescale 1ns / 1ps
module improved_gradient_noise import ign_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    ign_in_if.sink    i_in,
    ign_out_if.source o_out
);
    logic  en;
    logic  acc;
    logic  wr_ok;
    logic  we;
    t_tidx waddr;
    logic [7:0] wdata;

    logic  r_init;
    t_tidx r_init_idx;
    logic [7:1] r_vld;
    logic [4:1] r_2d;
    logic  r_ov;
    logic signed [OUT_W-1:0] r_onoise;

    t_tidx c_xi, c_yi, c_zi;
    t_frac c_xf, c_yf, c_zf;
    t_tidx r_yi1, r_zi1, r_zi2;
    t_frac r_xf [1:3];
    t_frac r_yf [1:3];
    t_frac r_zf [1:3];

    logic [7:0] ha, hb;
    logic [7:0] hbase [4];
    logic [7:0] hlo [4];
    logic [7:0] hhi [4];
    logic [7:0] r_h2 [4];
    t_val r_g [8];
    t_val g [8];
    t_fade fu, fv, fw, wsel;
    t_val res;
    logic signed [VW+OUT_W-1:0] rw;
    logic signed [OUT_W-1:0] sat;

    function automatic void split(input logic signed [31:0] c, output t_tidx lat,
                                  output t_frac frac);
        logic [47:0] ext;
        ext  = {{16{c[31]}}, c};
        lat  = ext[FRAC_BITS+TBL_AW-1:FRAC_BITS];
        frac = c[FRAC_BITS-1:0];
    endfunction

    assign en    = !r_ov || o_out.ready;
    assign wr_ok = !(r_vld[1] || r_vld[2]);
    assign i_in.ready = en && !r_init && (i_in.opcode != OP_WRITE || wr_ok);
    assign acc   = i_in.valid && i_in.ready;

    always_comb begin
        split(i_in.coord_x, c_xi, c_xf);
        split(i_in.coord_y, c_yi, c_yf);
        split(i_in.coord_z, c_zi, c_zf);
        if (r_init) begin
            we    = 1'b1;
            waddr = r_init_idx;
            wdata = STD_PERM[low_byte(r_init_idx)];
        end else begin
            we    = acc && i_in.opcode == OP_WRITE;
            waddr = byte_idx(i_in.entry_index);
            wdata = i_in.entry_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init     <= 1'b1;
            r_init_idx <= '0;
            r_vld      <= '0;
            r_ov       <= 1'b0;
        end else begin
            if (r_init) begin
                r_init_idx <= r_init_idx + 1'b1;
                if (r_init_idx == t_tidx'(TABLE_SIZE - 1)) begin
                    r_init <= 1'b0;
                end
            end
            if (en) begin
                r_vld <= {r_vld[6:1], acc && (i_in.opcode == OP_NOISE3 ||
                                              i_in.opcode == OP_NOISE2)};
                r_ov  <= r_vld[7];
            end
        end
    end

    ign_perm_ram u_ram_a (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata), .i_re(en),
        .i_raddr0(c_xi), .i_raddr1(c_xi + 1'b1), .o_rdata0(ha), .o_rdata1(hb)
    );

    ign_perm_ram u_ram_b0 (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata), .i_re(en),
        .i_raddr0(byte_idx(ha) + r_yi1), .i_raddr1(byte_idx(ha) + r_yi1 + 1'b1),
        .o_rdata0(hbase[0]), .o_rdata1(hbase[2])
    );

    ign_perm_ram u_ram_b1 (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata), .i_re(en),
        .i_raddr0(byte_idx(hb) + r_yi1), .i_raddr1(byte_idx(hb) + r_yi1 + 1'b1),
        .o_rdata0(hbase[1]), .o_rdata1(hbase[3])
    );

    for (genvar k = 0; k < 4; k++) begin : g_ram_c
        ign_perm_ram u_ram_c (
            .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata), .i_re(en),
            .i_raddr0(byte_idx(hbase[k]) + r_zi2),
            .i_raddr1(byte_idx(hbase[k]) + r_zi2 + 1'b1),
            .o_rdata0(hlo[k]), .o_rdata1(hhi[k])
        );
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            t_val xs, ys, zl, zh;
            xs = k[0] ? t_val'({4'b0, r_xf[3]}) - ONE_V : t_val'({4'b0, r_xf[3]});
            ys = k[1] ? t_val'({4'b0, r_yf[3]}) - ONE_V : t_val'({4'b0, r_yf[3]});
            zl = t_val'({4'b0, r_zf[3]});
            zh = zl - ONE_V;
            if (r_2d[3]) begin
                g[k]     = grad2(r_h2[k][1:0], xs, ys);
                g[k + 4] = '0;
            end else begin
                g[k]     = grad3(hlo[k][3:0], xs, ys, zl);
                g[k + 4] = grad3(hhi[k][3:0], xs, ys, zh);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_yi1 <= c_yi;
            r_zi1 <= c_zi;
            r_zi2 <= r_zi1;
            r_xf  <= '{c_xf, r_xf[1], r_xf[2]};
            r_yf  <= '{c_yf, r_yf[1], r_yf[2]};
            r_zf  <= '{c_zf, r_zf[1], r_zf[2]};
            r_2d  <= {r_2d[3:1], i_in.opcode == OP_NOISE2};
            r_h2  <= hbase;
            r_g   <= g;
            r_onoise <= sat;
        end
    end

    ign_fade u_fade_x (.i_clk(i_clk), .i_en(en), .i_t(r_xf[1]), .o_fade(fu));
    ign_fade u_fade_y (.i_clk(i_clk), .i_en(en), .i_t(r_yf[1]), .o_fade(fv));
    ign_fade u_fade_z (.i_clk(i_clk), .i_en(en), .i_t(r_zf[1]), .o_fade(fw));

    // 2D: zero weight on the far z plane leaves the y lerp as the result
    assign wsel = r_2d[4] ? '0 : fw;

    ign_blend u_blend (
        .i_clk(i_clk), .i_en(en), .i_g(r_g), .i_u(fu), .i_v(fv), .i_w(wsel),
        .o_res(res)
    );

    always_comb begin
        rw = {{OUT_W{res[VW-1]}}, res};
        if (rw > (VW+OUT_W)'(262143)) begin
            sat = OUT_W'(262143);
        end else if (rw < -(VW+OUT_W)'(262144)) begin
            sat = OUT_W'(-262144);
        end else begin
            sat = rw[OUT_W-1:0];
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.noise_value = r_onoise;

`ifndef ASSERT_OFF
    a_no_accept_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> !i_in.ready) else $error("beat accepted during table load");
    a_write_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_in.opcode == OP_WRITE) |-> !(r_vld[1] || r_vld[2]))
        else $error("table write overtook a lookup");
    a_noise_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_in.opcode == OP_NOISE3 || i_in.opcode == OP_NOISE2)) |=> r_vld[1])
        else $error("noise beat lost at entry");
`endif
endmodule

// ===== hw/rtl/ign_perm_ram.sv =====
// Permutation table copy: one write port, two registered read ports.
`timescale 1ns / 1ps
module ign_perm_ram import ign_pkg::*; (
    input  logic       i_clk,
    input  logic       i_we,
    input  t_tidx      i_waddr,
    input  logic [7:0] i_wdata,
    input  logic       i_re,
    input  t_tidx      i_raddr0,
    input  t_tidx      i_raddr1,
    output logic [7:0] o_rdata0,
    output logic [7:0] o_rdata1
);
    logic [7:0] r_mem [TABLE_SIZE];
    logic [7:0] r_rd0;
    logic [7:0] r_rd1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd0 <= r_mem[i_raddr0];
            r_rd1 <= r_mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rd0;
    assign o_rdata1 = r_rd1;
endmodule

// ===== hw/rtl/ign_fade.sv =====
// Three-stage quintic fade 6t^5 - 15t^4 + 10t^3, truncated products.
`timescale 1ns / 1ps
module ign_fade import ign_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_frac i_t,
    output t_fade o_fade
);
    localparam int KW = FRAC_BITS + 6;
    localparam int MW = FRAC_BITS + 5;
    localparam logic [KW-1:0] FIFTEEN = KW'(15) << FRAC_BITS;
    localparam logic [MW-1:0] TEN     = MW'(10) << FRAC_BITS;

    logic [2*FRAC_BITS-1:0]           tt;
    logic [KW-1:0]                    t6;
    logic signed [KW-1:0]             k;
    logic signed [FRAC_BITS+KW:0]     n_mp;
    logic [2*FRAC_BITS-1:0]           t3p;
    logic signed [FRAC_BITS+KW:0]     mp_sh;
    logic signed [FRAC_BITS+MW:0]     fp;

    t_frac                        r_t1;
    t_frac                        r_t2;
    logic signed [FRAC_BITS+KW:0] r_mp;
    t_frac                        r_t3;
    logic signed [MW-1:0]         r_m;
    t_fade                        r_fade;

    always_comb begin
        tt    = {{FRAC_BITS{1'b0}}, i_t} * {{FRAC_BITS{1'b0}}, i_t};
        t6    = ({6'b0, i_t} << 2) + ({6'b0, i_t} << 1);
        k     = $signed(t6 - FIFTEEN);
        n_mp  = $signed({1'b0, i_t}) * k;
        t3p   = {{FRAC_BITS{1'b0}}, r_t2} * {{FRAC_BITS{1'b0}}, r_t1};
        mp_sh = r_mp >>> FRAC_BITS;
        fp    = ($signed({1'b0, r_t3}) * r_m) >>> FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t1   <= i_t;
            r_t2   <= tt[2*FRAC_BITS-1:FRAC_BITS];
            r_mp   <= n_mp;
            r_t3   <= t3p[2*FRAC_BITS-1:FRAC_BITS];
            r_m    <= $signed(mp_sh[MW-1:0] + TEN);
            r_fade <= fp[FW-1:0];
        end
    end

    assign o_fade = r_fade;
endmodule

// ===== hw/rtl/ign_blend.sv =====
// Three-stage lerp tree: x lerps, y lerps, then z lerp.
`timescale 1ns / 1ps
module ign_blend import ign_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_val  i_g [8],
    input  t_fade i_u,
    input  t_fade i_v,
    input  t_fade i_w,
    output t_val  o_res
);
    t_prod r_pu [4];
    t_val  r_ga [4];
    t_fade r_v5;
    t_fade r_w5;
    t_prod r_pv [2];
    t_val  r_la [2];
    t_fade r_w6;
    t_prod r_pw;
    t_val  r_sa;

    t_val l [4];
    t_val s [2];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            l[i] = r_ga[i] + fx_shr(r_pu[i]);
        end
        for (int j = 0; j < 2; j++) begin
            s[j] = r_la[j] + fx_shr(r_pv[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 4; i++) begin
                r_pu[i] <= fx_mul(i_u, i_g[2*i+1] - i_g[2*i]);
                r_ga[i] <= i_g[2*i];
            end
            r_v5 <= i_v;
            r_w5 <= i_w;
            for (int j = 0; j < 2; j++) begin
                r_pv[j] <= fx_mul(r_v5, l[2*j+1] - l[2*j]);
                r_la[j] <= l[2*j];
            end
            r_w6 <= r_w5;
            r_pw <= fx_mul(r_w6, s[1] - s[0]);
            r_sa <= s[0];
        end
    end

    assign o_res = r_sa + fx_shr(r_pw);
endmodule

// ===== verif/improved_gradient_noise_test.sv =====
// Self-checking testbench for improved_gradient_noise: directed rows, then random beats.
`timescale 1ns / 1ps
module improved_gradient_noise_test;
    import ign_pkg::*;

    typedef struct {
        t_opcode                 op;
        logic [31:0]             x;
        logic [31:0]             y;
        logic [31:0]             z;
        logic [7:0]              idx;
        logic [7:0]              val;
        bit                      typed;
        logic signed [OUT_W-1:0] want;
    } t_req;

    localparam int  STALL_LIMIT = 5000;
    localparam int  N_RANDOM    = 1750;
    localparam longint ONE      = longint'(1) << FRAC_BITS;

    logic i_clk;
    logic i_rst_n;
    ign_in_if  in_if ();
    ign_out_if out_if ();

    improved_gradient_noise dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    logic [7:0]              perm_model [TABLE_SIZE];
    logic signed [OUT_W-1:0] pending_noise [$];
    t_req                    directed [$];
    bit                      cur_typed;
    logic signed [OUT_W-1:0] cur_want;
    bit                      no_idle;
    int                      n_errors;
    int                      n_checked;
    int                      n_writes;
    int                      n_sent;
    int                      idle_cycles;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic longint fade_of(longint t);
        longint t2, t3, m;
        t2 = (t * t) >>> FRAC_BITS;
        t3 = (t2 * t) >>> FRAC_BITS;
        m  = ((t * (6 * t - 15 * ONE)) >>> FRAC_BITS) + 10 * ONE;
        return (t3 * m) >>> FRAC_BITS;
    endfunction

    function automatic longint lerp_of(longint a, longint b, longint t);
        return a + ((t * (b - a)) >>> FRAC_BITS);
    endfunction

    function automatic int tab(longint i);
        return int'(perm_model[i & (TABLE_SIZE - 1)]);
    endfunction

    function automatic longint dot3(int hash, longint x, longint y, longint z);
        int     h;
        longint u, v;
        h = hash & 15;
        u = (h < 8) ? x : y;
        v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
        if (h[0]) u = -u;
        if (h[1]) v = -v;
        return u + v;
    endfunction

    function automatic longint dot2(int hash, longint x, longint y);
        case (hash & 3)
            0:       return x + y;
            1:       return y - x;
            2:       return x - y;
            default: return -x - y;
        endcase
    endfunction

    function automatic logic signed [OUT_W-1:0] noise_of(t_opcode op, logic [31:0] cx,
                                                         logic [31:0] cy, logic [31:0] cz);
        longint xi, yi, zi, xf, yf, zf, x0, y0, z0, u, v, w, l1, l2, s1, s2, r;
        int     a, b, aa, ab, ba, bb;
        xi = (longint'($signed(cx)) >>> FRAC_BITS) & (TABLE_SIZE - 1);
        yi = (longint'($signed(cy)) >>> FRAC_BITS) & (TABLE_SIZE - 1);
        zi = (longint'($signed(cz)) >>> FRAC_BITS) & (TABLE_SIZE - 1);
        xf = longint'(cx[FRAC_BITS-1:0]);
        yf = longint'(cy[FRAC_BITS-1:0]);
        zf = longint'(cz[FRAC_BITS-1:0]);
        x0 = xf - ONE;
        y0 = yf - ONE;
        z0 = zf - ONE;
        u = fade_of(xf);
        v = fade_of(yf);
        w = fade_of(zf);
        a = tab(xi);
        b = tab(xi + 1);
        if (op == OP_NOISE2) begin
            l1 = lerp_of(dot2(tab(a + yi), xf, yf), dot2(tab(b + yi), x0, yf), u);
            l2 = lerp_of(dot2(tab(a + yi + 1), xf, y0), dot2(tab(b + yi + 1), x0, y0), u);
            r = lerp_of(l1, l2, v);
        end else begin
            aa = tab(a + yi);
            ab = tab(a + yi + 1);
            ba = tab(b + yi);
            bb = tab(b + yi + 1);
            l1 = lerp_of(dot3(tab(aa + zi), xf, yf, zf), dot3(tab(ba + zi), x0, yf, zf), u);
            l2 = lerp_of(dot3(tab(ab + zi), xf, y0, zf), dot3(tab(bb + zi), x0, y0, zf), u);
            s1 = lerp_of(l1, l2, v);
            l1 = lerp_of(dot3(tab(aa + zi + 1), xf, yf, z0),
                         dot3(tab(ba + zi + 1), x0, yf, z0), u);
            l2 = lerp_of(dot3(tab(ab + zi + 1), xf, y0, z0),
                         dot3(tab(bb + zi + 1), x0, y0, z0), u);
            s2 = lerp_of(l1, l2, v);
            r = lerp_of(s1, s2, w);
        end
        if (r > 262143) r = 262143;
        if (r < -262144) r = -262144;
        return r[OUT_W-1:0];
    endfunction

    function automatic int gap_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom())};
            2:       return {$urandom_range(0, 1) == 1 ? 8'h80 : 8'h7F, 24'($urandom())};
            default: return {16'($urandom_range(0, 3) + 16'hFFFE), 16'($urandom())};
        endcase
    endfunction

    task automatic add_row(t_opcode op, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic [7:0] idx, logic [7:0] val, bit typed,
                           logic signed [OUT_W-1:0] want);
        t_req r;
        r = '{op, x, y, z, idx, val, typed, want};
        directed.push_back(r);
    endtask

    task automatic send(t_req r);
        int g;
        in_if.valid       <= 1'b1;
        in_if.opcode      <= r.op;
        in_if.coord_x     <= r.x;
        in_if.coord_y     <= r.y;
        in_if.coord_z     <= r.z;
        in_if.entry_index <= r.idx;
        in_if.entry_value <= r.val;
        cur_typed         <= r.typed;
        cur_want          <= r.want;
        do @(posedge i_clk); while (!in_if.ready);
        n_sent++;
        g = gap_len();
        if (g > 0) begin
            in_if.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_noise.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_req(output t_req r);
        int k;
        k = $urandom_range(0, 99);
        r.op = (k < 46) ? OP_NOISE3 : (k < 84) ? OP_NOISE2 : (k < 97) ? OP_WRITE : OP_NONE;
        r.x = rand_coord();
        r.y = rand_coord();
        r.z = rand_coord();
        r.idx = 8'($urandom());
        r.val = 8'($urandom());
        r.typed = 1'b0;
        r.want = '0;
    endtask

    // monitor: predicts on request beats, checks result beats
    always @(posedge i_clk) begin
        logic signed [OUT_W-1:0] exp_v;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_SIZE; i++) perm_model[i] <= STD_PERM[i % 256];
            idle_cycles <= 0;
        end else begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (in_if.valid && in_if.ready) begin
                case (t_opcode'(in_if.opcode))
                    OP_WRITE: begin
                        perm_model[in_if.entry_index & (TABLE_SIZE - 1)] <= in_if.entry_value;
                        n_writes++;
                    end
                    OP_NOISE3, OP_NOISE2: begin
                        if (cur_typed)
                            pending_noise.push_back(cur_want);
                        else
                            pending_noise.push_back(noise_of(t_opcode'(in_if.opcode),
                                in_if.coord_x, in_if.coord_y, in_if.coord_z));
                    end
                    default: ;
                endcase
            end
            if (out_if.valid && out_if.ready) begin
                if (pending_noise.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected result beat: noise_value=%0d", out_if.noise_value);
                end else begin
                    exp_v = pending_noise.pop_front();
                    n_checked++;
                    if (out_if.noise_value !== exp_v) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("noise_value mismatch: expected %0d, got %0d",
                                     exp_v, out_if.noise_value);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || no_idle)
            out_if.ready <= 1'b1;
        else if ($urandom_range(0, 99) < 4)
            out_if.ready <= 1'b0;
        else if (!out_if.ready && $urandom_range(0, 99) < 8)
            out_if.ready <= 1'b0;
        else
            out_if.ready <= $urandom_range(0, 99) < 80;
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
            $display("improved_gradient_noise_test NOT OK");
            $finish;
        end
    end

    initial begin
        t_req r;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.opcode = OP_NONE;
        in_if.coord_x = '0;
        in_if.coord_y = '0;
        in_if.coord_z = '0;
        in_if.entry_index = '0;
        in_if.entry_value = '0;
        out_if.ready = 1'b1;
        cur_typed = 1'b0;
        cur_want = '0;
        no_idle = 1'b0;
        n_errors = 0;
        n_checked = 0;
        n_writes = 0;
        n_sent = 0;
        idle_cycles = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // lattice points give zero; other rows take their expected value from noise_of
        add_row(OP_NOISE3, 32'h0, 32'h0, 32'h0, 8'h0, 8'h0, 1, '0);
        add_row(OP_NOISE2, 32'h0, 32'h0, 32'h0, 8'h0, 8'h0, 1, '0);
        add_row(OP_NOISE3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'h0, 8'h0, 1, '0);
        add_row(OP_NOISE2, 32'h8000_0000, 32'h7FFF_0000, 32'h0, 8'h0, 8'h0, 1, '0);
        add_row(OP_NOISE3, 32'h00FF_0000, 32'hFFFF_0000, 32'h0012_0000, 8'h0, 8'h0, 1, '0);
        add_row(OP_NOISE3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'h0, 8'h0, 0, '0);
        add_row(OP_NOISE2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 8'h0, 8'h0, 0, '0);
        add_row(OP_NOISE3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h0, 8'h0, 0, '0);
        add_row(OP_NOISE2, 32'hFFFF_FFFF, 32'h8000_0001, 32'h0, 8'h0, 8'h0, 0, '0);
        add_row(OP_NOISE3, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 8'h0, 8'h0, 0, '0);
        add_row(OP_NOISE2, 32'h0001_4000, 32'h0003_C000, 32'h0, 8'h0, 8'h0, 0, '0);
        add_row(OP_NOISE3, 32'h00FF_8000, 32'h00FF_C000, 32'h00FF_4000, 8'h0, 8'h0, 0, '0);
        add_row(OP_NOISE2, 32'h00FF_FFFF, 32'h00FF_0001, 32'h0, 8'h0, 8'h0, 0, '0);
        add_row(OP_NONE, 32'h1234_5678, 32'h0, 32'h0, 8'h0, 8'h0, 0, '0);
        add_row(OP_WRITE, 32'h0, 32'h0, 32'h0, 8'h00, 8'hFF, 0, '0);
        add_row(OP_WRITE, 32'h0, 32'h0, 32'h0, 8'hFF, 8'h00, 0, '0);
        add_row(OP_WRITE, 32'hFFFF_FFFF, 32'h0, 32'h0, 8'h80, 8'h80, 0, '0);
        add_row(OP_NOISE3, 32'h0000_8000, 32'h00FF_8000, 32'h0000_4000, 8'h0, 8'h0, 0, '0);
        add_row(OP_NOISE2, 32'h00FF_8000, 32'h0000_8000, 32'h0, 8'h0, 8'h0, 0, '0);
        add_row(OP_NOISE3, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'h0, 8'h0, 1, '0);
        foreach (directed[i]) send(directed[i]);
        drain();

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 300 || i == 1200) drain();
            no_idle = (i >= 600 && i < 800);
            random_req(r);
            send(r);
        end
        drain();
        repeat (20) @(posedge i_clk);

        $display("covered %0d request beats (%0d table writes), %0d noise results checked",
                 n_sent, n_writes, n_checked);
        if (n_errors == 0 && pending_noise.size() == 0)
            $display("improved_gradient_noise_test OK");
        else
            $display("improved_gradient_noise_test NOT OK");
        $finish;
    end
endmodule
